[design/bamtr_pkg.sv]
// ----------------------------------------------------------------------------
// bamtr_pkg
// Shared types and constants for the broadcast transport reassembler.
// ----------------------------------------------------------------------------
package bamtr_pkg;

  // default packet store depth
  localparam int DEF_MAX_PACKETS = 32;

  // bytes carried by one data frame
  localparam int          PKT_BYTES   = 7;
  localparam int          PKT_W       = 8 * PKT_BYTES;
  localparam logic [2:0]  FULL_BYTES  = 3'd7;

  // broadcast announce control byte
  localparam logic [7:0]  CTRL_BAM    = 8'd32;

  // frame kinds carried in tuser
  localparam logic [1:0]  MODE_ANNOUNCE = 2'd0;
  localparam logic [1:0]  MODE_DATA     = 2'd1;

  // session status codes
  typedef enum logic [1:0] {
    STAT_NONE       = 2'd0,
    STAT_OK         = 2'd1,
    STAT_INCOMPLETE = 2'd2,
    STAT_UNEXPECTED = 2'd3
  } status_e;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_e;

  // input frame fields (tdata layout, first field in the high bits)
  typedef struct packed {
    logic [PKT_W-1:0] payload;
    logic [7:0]       sequence_req;
    logic [7:0]       source_address;
    logic [2:0]       priority_req;
    logic [17:0]      group_number;
    logic [10:0]      total_size;
    logic [7:0]       total_packets;
    logic [7:0]       ctrl_type;
  } item_t;

  // one result
  typedef struct packed {
    logic             last;
    logic [2:0]       chunk_bytes;
    logic [PKT_W-1:0] chunk;
    logic [28:0]      message_id;
    logic             has_data;
    status_e          status;
  } res_t;

endpackage

[design/bamtr_store.sv]
// ----------------------------------------------------------------------------
// bamtr_store
// Packet store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bamtr_store
  import bamtr_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_PACKETS,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [PKT_W-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [PKT_W-1:0] rd_data_o
);

  logic [PKT_W-1:0] mem [DEPTH];
  logic [PKT_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data valid in the cycle after the read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/bamtr_ctrl.sv]
// ----------------------------------------------------------------------------
// bamtr_ctrl
// Session control: header registers, frame checks and the drain sequencer
// that reads stored packets back as message chunks.
// ----------------------------------------------------------------------------
module bamtr_ctrl
  import bamtr_pkg::*;
#(
  parameter int MAX_PACKETS = DEF_MAX_PACKETS,
  localparam int AW         = $clog2(MAX_PACKETS),
  localparam int CW         = $clog2(MAX_PACKETS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request side
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       in_mode_i,
  input  item_t            in_item_i,
  // result side
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o,
  // packet store
  output logic             wr_en_o,
  output logic [AW-1:0]    wr_addr_o,
  output logic [PKT_W-1:0] wr_data_o,
  output logic             rd_en_o,
  output logic [AW-1:0]    rd_addr_o,
  input  logic [PKT_W-1:0] rd_data_i
);

  state_e      state_q, state_d;
  logic        in_session_q, in_session_d;
  logic [CW-1:0] last_seq_q, last_seq_d;
  logic [CW-1:0] hdr_packets_q, hdr_packets_d;
  logic [10:0] hdr_size_q, hdr_size_d;
  logic [17:0] hdr_group_q, hdr_group_d;
  logic [2:0]  hdr_prio_q, hdr_prio_d;
  logic [7:0]  hdr_src_q, hdr_src_d;
  status_e     sess_status_q, sess_status_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [10:0] left_q, left_d;

  logic        accept;
  logic        seq_ok;
  logic [2:0]  nb;
  logic        chunk_last;
  logic [PKT_W-1:0] chunk_masked;
  logic [28:0] msg_id;

  // drain helpers
  assign nb         = (left_q < 11'(PKT_BYTES)) ? left_q[2:0] : FULL_BYTES;
  assign chunk_last = (left_q == 11'(nb)) || ((idx_q + CW'(1)) == hdr_packets_q);
  assign msg_id     = {hdr_prio_q, hdr_group_q, hdr_src_q};

  // keep only the valid bytes of the last chunk
  always_comb begin
    for (int b = 0; b < PKT_BYTES; b++) begin
      chunk_masked[8*b +: 8] = (3'(b) < nb) ? rd_data_i[8*b +: 8] : 8'd0;
    end
  end

  // request taken only in idle and when the result can leave
  assign accept = in_valid_i && res_ready_i && (state_q == S_IDLE);
  assign seq_ok = (in_item_i.sequence_req <= 8'(hdr_packets_q)) &&
                  (in_item_i.sequence_req == (8'(last_seq_q) + 8'd1));

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      in_session_q  <= 1'b0;
      last_seq_q    <= '0;
      hdr_packets_q <= '0;
      hdr_size_q    <= '0;
      hdr_group_q   <= '0;
      hdr_prio_q    <= '0;
      hdr_src_q     <= '0;
      sess_status_q <= STAT_NONE;
      idx_q         <= '0;
      left_q        <= '0;
    end else begin
      state_q       <= state_d;
      in_session_q  <= in_session_d;
      last_seq_q    <= last_seq_d;
      hdr_packets_q <= hdr_packets_d;
      hdr_size_q    <= hdr_size_d;
      hdr_group_q   <= hdr_group_d;
      hdr_prio_q    <= hdr_prio_d;
      hdr_src_q     <= hdr_src_d;
      sess_status_q <= sess_status_d;
      idx_q         <= idx_d;
      left_q        <= left_d;
    end
  end

  // next state, checks and outputs
  always_comb begin
    logic end_sess;
    logic emit;

    end_sess      = 1'b0;
    emit          = 1'b0;
    state_d       = state_q;
    in_session_d  = in_session_q;
    last_seq_d    = last_seq_q;
    hdr_packets_d = hdr_packets_q;
    hdr_size_d    = hdr_size_q;
    hdr_group_d   = hdr_group_q;
    hdr_prio_d    = hdr_prio_q;
    hdr_src_d     = hdr_src_q;
    sess_status_d = sess_status_q;
    idx_d         = idx_q;
    left_d        = left_q;

    in_ready_o    = 1'b0;
    res_valid_o   = 1'b0;
    res_o         = '0;
    wr_en_o       = 1'b0;
    wr_addr_o     = AW'(in_item_i.sequence_req - 8'd1);
    wr_data_o     = in_item_i.payload;
    rd_en_o       = 1'b0;
    rd_addr_o     = idx_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        in_ready_o = res_ready_i;
        if (accept) begin
          emit = 1'b1;
          case (in_mode_i)
            MODE_ANNOUNCE: begin
              if (in_session_q) begin
                end_sess      = 1'b1;
                sess_status_d = STAT_INCOMPLETE;
              end else if (in_item_i.ctrl_type != CTRL_BAM ||
                           in_item_i.total_packets > 8'(MAX_PACKETS)) begin
                end_sess      = 1'b1;
                sess_status_d = STAT_UNEXPECTED;
              end else begin
                in_session_d  = 1'b1;
                hdr_packets_d = CW'(in_item_i.total_packets);
                hdr_size_d    = in_item_i.total_size;
                hdr_group_d   = in_item_i.group_number;
                hdr_prio_d    = in_item_i.priority_req;
                hdr_src_d     = in_item_i.source_address;
              end
            end
            MODE_DATA: begin
              if (!in_session_q) begin
                sess_status_d = STAT_UNEXPECTED;
              end else if (!seq_ok) begin
                end_sess      = 1'b1;
                sess_status_d = STAT_UNEXPECTED;
              end else begin
                wr_en_o    = 1'b1;
                last_seq_d = CW'(in_item_i.sequence_req);
                if (in_item_i.sequence_req == 8'(hdr_packets_q)) begin
                  if (hdr_size_q == 11'd0) begin
                    // empty message: one ok result, no chunk
                    end_sess      = 1'b1;
                    sess_status_d = STAT_OK;
                  end else begin
                    // final packet: drain the store
                    emit    = 1'b0;
                    idx_d   = '0;
                    left_d  = hdr_size_q;
                    state_d = S_READ;
                  end
                end
              end
            end
            default: begin
              end_sess      = 1'b1;
              sess_status_d = STAT_UNEXPECTED;
            end
          endcase
          if (emit) begin
            res_valid_o = 1'b1;
            res_o.status = sess_status_d;
            res_o.last   = 1'b1;
          end
        end
      end
      S_READ: begin
        rd_en_o = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        res_valid_o       = 1'b1;
        res_o.status      = STAT_OK;
        res_o.has_data    = 1'b1;
        res_o.message_id  = msg_id;
        res_o.chunk       = chunk_masked;
        res_o.chunk_bytes = nb;
        res_o.last        = chunk_last;
        if (res_ready_i) begin
          left_d = left_q - 11'(nb);
          idx_d  = idx_q + CW'(1);
          if (chunk_last) begin
            end_sess      = 1'b1;
            sess_status_d = STAT_OK;
            state_d       = S_IDLE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // session teardown
    if (end_sess) begin
      in_session_d  = 1'b0;
      last_seq_d    = '0;
      hdr_packets_d = '0;
      hdr_size_d    = '0;
      hdr_group_d   = '0;
      hdr_prio_d    = '0;
      hdr_src_d     = '0;
    end
  end

  // drain only runs inside an open session
  a_drain_in_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_session_q)
    else $error("drain without open session");

  // a store read is always followed by its chunk
  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_EMIT))
    else $error("store read not followed by emit");

  // chunks always report ok
  a_chunk_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.has_data) |-> (res_o.status == STAT_OK))
    else $error("chunk with status other than ok");

  // no new request while draining
  a_no_accept_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("request accepted during drain");

  // drain finishes with the session closed and status ok
  a_drain_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && res_ready_i && chunk_last) |=>
      (!in_session_q && sess_status_q == STAT_OK))
    else $error("drain did not close session");

endmodule

[design/bam_transport_reassembler_core.sv]
// A request that does not complete a message gives its result in the output
// register in the cycle after it is taken; one request per cycle then, while
// the output register can take it and no drain runs. A final packet drains
// the store chunk by chunk: a read of the store read port, then the chunk.
// Reset clears the session and output control; the packet store keeps
// its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// bam_transport_reassembler_core
// Broadcast transport session reassembler with packet store and output stage.
// ----------------------------------------------------------------------------
module bam_transport_reassembler_core
  import bamtr_pkg::*;
#(
  parameter int MAX_PACKETS = DEF_MAX_PACKETS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ctrl_type, total_packets, total_size, group_number, priority_req,
  // source_address, sequence_req, payload
  input  logic [119:0] s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, message_id, chunk, chunk_bytes, zero fill
  output logic [95:0]  m_axis_tdata,
  // has_data
  output logic         m_axis_tuser,
  // last
  output logic         m_axis_tlast
);

  localparam int AW = $clog2(MAX_PACKETS);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [PKT_W-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [PKT_W-1:0] rd_data;

  logic             out_vld_q;
  res_t             out_q;

  bamtr_ctrl #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_item_i   (item_t'(s_axis_tdata)),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  bamtr_store #(
    .DEPTH (MAX_PACKETS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // output register: takes a new result when empty or while the old one leaves
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  // result packing
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_q.chunk_bytes, out_q.chunk, out_q.message_id,
                          out_q.status};
  assign m_axis_tuser  = out_q.has_data;
  assign m_axis_tlast  = out_q.last;

endmodule

[tb/sv/bam_transport_reassembler_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bam_transport_reassembler_core_test
// Self-checking bench for the broadcast transport reassembler. Frames go in on
// the request stream, and a predictor in the bench rebuilds each session and
// queues the results it expects. Every result taken from the output stream is
// checked field by field against the oldest one in that queue. Stimulus is a
// directed set of corner cases, then a full store drained under a long output
// hold, then random sessions with broken sequences and noise frames mixed in.
// ----------------------------------------------------------------------------
module bam_transport_reassembler_core_test;
  import bamtr_pkg::*;

  localparam int          DEPTH          = DEF_MAX_PACKETS;
  localparam logic [1:0]  MODE_OTHER     = 2'd2;
  localparam logic [1:0]  MODE_RESERVED  = 2'd3;
  localparam int          MAX_WAIT       = 9;
  localparam int          LONG_HOLD      = 400;
  localparam int          DRAIN_CYCLES   = 2 * DEPTH + 16;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          RANDOM_FRAMES  = 12;
  localparam int          MAX_SIZE       = 1785;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = MODE_ANNOUNCE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  bam_transport_reassembler_core #(
    .MAX_PACKETS(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // session state kept by the predictor
  logic             sess_open;
  logic [7:0]       sess_last_seq;
  logic [7:0]       sess_packets;
  logic [10:0]      sess_size;
  logic [17:0]      sess_group;
  logic [2:0]       sess_priority;
  logic [7:0]       sess_source;
  status_e          sess_status;
  logic [PKT_W-1:0] packet_mem [DEPTH];
  res_t             pending_results [$];

  // idle control and bookkeeping
  int unsigned src_wait_max   = 0;
  int unsigned rcv_wait_max   = 0;
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  logic        hold_request   = 1'b0;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatches     = 0;
  int unsigned frames_sent    = 0;
  int unsigned results_seen   = 0;
  int unsigned messages_built = 0;

  function automatic void close_session();
    sess_open     = 1'b0;
    sess_last_seq = '0;
    sess_packets  = '0;
    sess_size     = '0;
    sess_group    = '0;
    sess_priority = '0;
    sess_source   = '0;
  endfunction

  function automatic res_t status_only(status_e st);
    res_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // append one expected result at the tail of the queue
  function automatic void queue_result(res_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // queue what one accepted frame should produce and advance the session
  function automatic void reassemble_frame(logic [1:0] mode, item_t it);
    res_t             r;
    logic [28:0]      id;
    logic [PKT_W-1:0] c;
    int               left;
    int               nb;
    int               i;
    logic             emitted;
    emitted = 1'b0;
    if (mode == MODE_ANNOUNCE) begin
      if (sess_open) begin
        close_session();
        sess_status = STAT_INCOMPLETE;
      end else if (it.ctrl_type != CTRL_BAM || int'(it.total_packets) > DEPTH) begin
        close_session();
        sess_status = STAT_UNEXPECTED;
      end else begin
        sess_open     = 1'b1;
        sess_packets  = it.total_packets;
        sess_size     = it.total_size;
        sess_group    = it.group_number;
        sess_priority = it.priority_req;
        sess_source   = it.source_address;
      end
    end else if (mode == MODE_DATA) begin
      if (!sess_open) begin
        sess_status = STAT_UNEXPECTED;
      end else if (it.sequence_req > sess_packets ||
                   int'(it.sequence_req) != int'(sess_last_seq) + 1) begin
        close_session();
        sess_status = STAT_UNEXPECTED;
      end else begin
        packet_mem[int'(it.sequence_req) - 1] = it.payload;
        sess_last_seq = it.sequence_req;
        if (it.sequence_req == sess_packets) begin
          // final packet: emit the message chunk by chunk
          id   = {sess_priority, sess_group, sess_source};
          left = int'(sess_size);
          for (i = 0; i < int'(sess_packets) && left > 0; i++) begin
            nb = (left < PKT_BYTES) ? left : PKT_BYTES;
            c  = packet_mem[i];
            if (nb < PKT_BYTES) c = c & ~({PKT_W{1'b1}} << (8 * nb));
            left          -= nb;
            r              = '0;
            r.status       = STAT_OK;
            r.has_data     = 1'b1;
            r.message_id   = id;
            r.chunk        = c;
            r.chunk_bytes  = 3'(nb);
            r.last         = (left == 0 || i + 1 == int'(sess_packets));
            queue_result(r);
            emitted = 1'b1;
          end
          close_session();
          sess_status = STAT_OK;
          if (!emitted) queue_result(status_only(STAT_OK));
          return;
        end
      end
    end else begin
      close_session();
      sess_status = STAT_UNEXPECTED;
    end
    queue_result(status_only(sess_status));
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.ctrl_type      = 8'($urandom);
    it.total_packets  = 8'($urandom);
    it.total_size     = 11'($urandom_range(0, MAX_SIZE));
    it.group_number   = 18'($urandom);
    it.priority_req   = 3'($urandom);
    it.source_address = 8'($urandom);
    it.sequence_req   = 8'($urandom);
    it.payload        = PKT_W'({$urandom, $urandom});
    return it;
  endfunction

  // offer one request and wait for it to be taken; valid stays high when the
  // next request follows with no gap
  task automatic send_frame(logic [1:0] mode, item_t it);
    int unsigned gap;
    gap = $urandom_range(0, src_wait_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    reassemble_frame(mode, it);
    frames_sent++;
  endtask

  task automatic send_announce(logic [7:0] ctrl, logic [7:0] pk, logic [10:0] size,
                               logic [17:0] pgn, logic [2:0] prio, logic [7:0] src);
    item_t it;
    it                = random_item();
    it.ctrl_type      = ctrl;
    it.total_packets  = pk;
    it.total_size     = size;
    it.group_number   = pgn;
    it.priority_req   = prio;
    it.source_address = src;
    send_frame(MODE_ANNOUNCE, it);
  endtask

  task automatic send_data(logic [7:0] seq, logic [PKT_W-1:0] bytes);
    item_t it;
    it              = random_item();
    it.sequence_req = seq;
    it.payload      = bytes;
    send_frame(MODE_DATA, it);
  endtask

  task automatic open_random_session(int n, int size);
    send_announce(CTRL_BAM, 8'(n), 11'(size), 18'($urandom), 3'($urandom), 8'($urandom));
  endtask

  // well-formed session: announce then every packet in order
  task automatic send_session(int n, int size);
    int s;
    open_random_session(n, size);
    for (s = 1; s <= n; s++) send_data(8'(s), PKT_W'({$urandom, $urandom}));
  endtask

  // mostly short sessions, a few up to the full store
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 4);
    if (r < 9) return $urandom_range(5, 12);
    return $urandom_range(13, DEPTH);
  endfunction

  function automatic int pick_size(int n);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(0, MAX_SIZE);
    if (r < 4) return $urandom_range(0, n * PKT_BYTES + 10);
    return $urandom_range(n * PKT_BYTES - 6, n * PKT_BYTES);
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // tdata: status [1:0], message_id [30:2], chunk [86:31], chunk_bytes [89:87]
  task automatic check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with none expected, expected nothing, actual tdata %0h",
               $time, m_axis_tdata);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      compare_field("status", 64'(want.status), 64'(m_axis_tdata[1:0]));
      compare_field("has_data", 64'(want.has_data), 64'(m_axis_tuser));
      compare_field("message_id", 64'(want.message_id), 64'(m_axis_tdata[30:2]));
      compare_field("chunk", 64'(want.chunk), 64'(m_axis_tdata[86:31]));
      compare_field("chunk_bytes", 64'(want.chunk_bytes), 64'(m_axis_tdata[89:87]));
      compare_field("last", 64'(want.last), 64'(m_axis_tlast));
      results_seen++;
      if (want.has_data && want.last) messages_built++;
    end
  endtask

  // result side: check each result, then stall at random or hold off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        stall_left = $urandom_range(0, rcv_wait_max);
        m_axis_tready <= (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= (stall_left == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // corner cases of the session rules
  task automatic test_directed_cases();
    src_wait_max = 3;
    rcv_wait_max = 3;
    send_data(8'd1, {PKT_W{1'b1}});                         // data with no session
    send_announce(CTRL_BAM, 8'd2, 11'd10, 18'h3FFFF, 3'd7, 8'hFF);
    send_data(8'd1, {PKT_W{1'b1}});
    send_data(8'd2, 56'h12_3456_789A_BCDE);                 // short last chunk
    send_announce(8'hFF, 8'd1, 11'd7, '0, '0, '0);          // not a broadcast
    send_announce(CTRL_BAM, 8'd33, 11'd7, '0, '0, '0);      // count above depth
    send_announce(CTRL_BAM, 8'hFF, 11'd1785, '0, '0, '0);
    send_announce(CTRL_BAM, 8'd1, 11'd0, '0, '0, '0);       // empty message
    send_data(8'd1, '0);
    send_announce(CTRL_BAM, 8'd3, 11'd1785, 18'h15555, 3'd5, 8'h5A); // size past packets
    send_data(8'd1, 56'hAA_AAAA_AAAA_AAAA);
    send_data(8'd2, 56'h55_5555_5555_5555);
    send_data(8'd3, 56'h01_0203_0405_0607);
    send_announce(CTRL_BAM, 8'd2, 11'd14, 18'h2AAAA, 3'd2, 8'hA5);
    send_data(8'd1, 56'h77_6655_4433_2211);
    send_data(8'd3, 56'h77_6655_4433_2211);                 // skipped sequence
    send_announce(CTRL_BAM, 8'd2, 11'd5, '0, '0, '0);
    send_announce(CTRL_BAM, 8'd2, 11'd5, '0, '0, '0);       // announce mid-session
    send_announce(CTRL_BAM, 8'd0, 11'd7, '0, '0, '0);       // zero packets
    send_data(8'd1, '1);
    send_announce(CTRL_BAM, 8'd1, 11'd3, '0, '0, '0);
    send_data(8'd0, '1);                                    // sequence zero
    send_frame(MODE_OTHER, random_item());
    send_announce(CTRL_BAM, 8'd1, 11'd3, '0, '0, '0);
    send_frame(MODE_RESERVED, random_item());               // other frame mid-session
  endtask

  // full store drained while the result side holds off, so the input stalls
  task automatic test_full_store_backpressure();
    src_wait_max = 0;
    rcv_wait_max = 0;
    hold_request = 1'b1;
    send_session(DEPTH, MAX_SIZE);
    send_session(DEPTH, DEPTH * PKT_BYTES);
  endtask

  // random sessions, some cut short, with noise frames in between
  task automatic test_random_sessions();
    int unsigned first;
    int          n;
    int          k;
    int          s;
    first = frames_sent;
    while (frames_sent - first < RANDOM_FRAMES) begin
      if ($urandom_range(0, 3) == 0) begin
        src_wait_max = $urandom_range(0, 1) ? MAX_WAIT : 0;
        rcv_wait_max = $urandom_range(0, 1) ? MAX_WAIT : 0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          n = pick_count();
          send_session(n, pick_size(n));
        end
        6, 7: begin
          n = pick_count();
          k = $urandom_range(0, n - 1);
          open_random_session(n, pick_size(n));
          for (s = 1; s <= k; s++) send_data(8'(s), PKT_W'({$urandom, $urandom}));
          case ($urandom_range(0, 3))
            0: send_data(8'(k + 2), PKT_W'({$urandom, $urandom}));
            1: open_random_session(pick_count(), 0);
            2: send_frame($urandom_range(0, 1) ? MODE_OTHER : MODE_RESERVED, random_item());
            default: send_data(8'(k), PKT_W'({$urandom, $urandom}));
          endcase
        end
        default: send_frame(2'($urandom_range(0, 3)), random_item());
      endcase
    end
  endtask

  initial begin
    close_session();
    sess_status = STAT_NONE;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_full_store_backpressure();
    test_random_sessions();
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      mismatches++;
    end

    $display("Sent %0d frames: corner cases, a full store under a long output hold,",
             frames_sent);
    $display("random sessions and noise; %0d results checked, %0d messages rebuilt.",
             results_seen, messages_built);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
design/bamtr_pkg.sv
design/bamtr_store.sv
design/bamtr_ctrl.sv
design/bam_transport_reassembler_core.sv
tb/sv/bam_transport_reassembler_core_test.sv
